// ===== src/gaussian_blur_3x3_unit_macros.svh =====
// assertion helpers for the blur unit
`ifndef GAUSSIAN_BLUR_3X3_UNIT_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_UNIT_MACROS_SVH

// same-cycle implication
`define GB_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define GB_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== src/gblur3_pkg.sv =====
// ----------------------------------------------------------------------------
// gblur3_pkg
// Shared types and constants of the 3x3 gaussian blur unit.
// ----------------------------------------------------------------------------
package gblur3_pkg;

   localparam int PIXEL_BITS  = 8;
   localparam int ROW_BITS    = 16;
   localparam int OUT_COL_BITS = 10;
   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // result queue sizing, room for two requests worth of results plus slack
   localparam int QUEUE_DEPTH      = 8;
   localparam int QUEUE_PTR_BITS   = 3;
   localparam int QUEUE_LEVEL_BITS = 4;
   localparam int MAX_RESULTS      = 3;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]   pixel;
      logic [ROW_BITS-1:0]     row;
      logic [OUT_COL_BITS-1:0] col;
      logic                    border;
      logic                    last;
   } gblur3_result_type;

   typedef struct packed {
      logic [1:0]                              count;
      gblur3_result_type [MAX_RESULTS-1:0]     entry;
   } gblur3_push_type;

endpackage

// ===== src/gblur3_ram.sv =====
// ----------------------------------------------------------------------------
// gblur3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gblur3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gblur3_result_queue.sv =====
// ----------------------------------------------------------------------------
// gblur3_result_queue
// Small result queue taking up to three results per cycle, giving one.
// ----------------------------------------------------------------------------
module gblur3_result_queue
   import gblur3_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  gblur3_push_type             push,
   input  logic                        pop,
   output logic                        head_valid,
   output gblur3_result_type           head,
   output logic [QUEUE_LEVEL_BITS-1:0] level
);

   gblur3_result_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LEVEL_BITS-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      level_in  = level_ff + QUEUE_LEVEL_BITS'(push.count) - QUEUE_LEVEL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_ptr_ff + QUEUE_PTR_BITS'(i)] <= push.entry[i];
         end
      end
   end

   assign head_valid = (level_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

// ===== src/gaussian_blur_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_unit
// Streaming 3x3 gaussian blur over a raster-order grayscale image.
//
//   channel  dir  handshake        payload
//   req_     in   valid / stall    pixel_in
//   rsp_     out  valid / stall    pixel_out, out_row, out_col, is_border,
//                                  last_of_run
//   csr_     in   valid / ready    index, wdata
//
// One request per cycle while the result queue has room; results leave one
// per cycle while rsp_stall is low, so on the last image row (one to three
// results per request) the response port sets the pace. An accepted request
// is registered in the input stage, and its results join the queue behind
// any still queued. Synchronous reset clears counters, window and queue; the
// line RAM is not cleared and needs no sweep. A stalled response port backs
// up into req_stall once the queue cannot hold another request's results.
// ----------------------------------------------------------------------------
`include "gaussian_blur_3x3_unit_macros.svh"

module gaussian_blur_3x3_unit
   import gblur3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIXEL_BITS-1:0]     req_pixel_in,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PIXEL_BITS-1:0]     rsp_pixel_out,
   output logic [ROW_BITS-1:0]       rsp_out_row,
   output logic [OUT_COL_BITS-1:0]   rsp_out_col,
   output logic                      rsp_is_border,
   output logic                      rsp_last_of_run,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int WCMP = (WW > CFG_WIDTH_BITS) ? WW : CFG_WIDTH_BITS;

   // configuration
   logic [CFG_WIDTH_BITS-1:0]  image_width_ff;
   logic [CFG_HEIGHT_BITS-1:0] image_height_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CFG_WIDTH_BITS'(640);
         image_height_ff <= CFG_HEIGHT_BITS'(480);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[CFG_WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[CFG_HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic [WCMP-1:0]     width_ext;
   logic [WCMP-1:0]     width_sat;
   logic [WW-1:0]       width_eff;
   logic [ROW_BITS-1:0] height_eff;

   always_comb begin
      width_ext = WCMP'(image_width_ff);
      if (width_ext < WCMP'(3)) begin
         width_sat = WCMP'(3);
      end else if (width_ext > WCMP'(MAX_WIDTH)) begin
         width_sat = WCMP'(MAX_WIDTH);
      end else begin
         width_sat = width_ext;
      end
      width_eff  = width_sat[WW-1:0];
      height_eff = (image_height_ff < ROW_BITS'(3)) ? ROW_BITS'(3) : image_height_ff;
   end

   // position counters and input register
   logic                  accept;
   logic [CW-1:0]         col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [CW-1:0]         col_pre;
   logic [ROW_BITS-1:0]   row_pre, row_wrap;
   logic                  last_col_pre, last_row_pre;

   assign accept = req_valid && !req_stall;

   always_comb begin
      // wrap a position left outside a shrunk image
      if (WW'(col_ff) >= width_eff) begin
         col_pre  = '0;
         row_wrap = row_ff + ROW_BITS'(1);
      end else begin
         col_pre  = col_ff;
         row_wrap = row_ff;
      end
      row_pre      = (row_wrap >= height_eff) ? '0 : row_wrap;
      last_col_pre = (WW'(col_pre) == width_eff - WW'(1));
      last_row_pre = (row_pre == height_eff - ROW_BITS'(1));

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col_pre) begin
            col_in = '0;
            row_in = last_row_pre ? '0 : row_pre + ROW_BITS'(1);
         end else begin
            col_in = col_pre + CW'(1);
            row_in = row_pre;
         end
      end
   end

   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_px_ff;
   logic [CW-1:0]         s1_col_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic                  s1_last_col_ff;
   logic                  s1_last_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= req_pixel_in;
         s1_col_ff      <= col_pre;
         s1_row_ff      <= row_pre;
         s1_last_col_ff <= last_col_pre;
         s1_last_row_ff <= last_row_pre;
      end
   end

   // line RAM: older row in the upper byte, newer row in the lower byte
   logic [2*PIXEL_BITS-1:0] line_q;
   logic [PIXEL_BITS-1:0]   top, mid;

   gblur3_ram #(
      .WIDTH (2 * PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({mid, s1_px_ff}),
      .rd_en   (accept),
      .rd_addr (col_pre),
      .rd_data (line_q)
   );

   assign top = line_q[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid = line_q[PIXEL_BITS-1:0];

   // window: 0..2 previous column (top, mid, bottom), 3..5 the one before
   logic [PIXEL_BITS-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top;
         win_ff[1] <= mid;
         win_ff[2] <= s1_px_ff;
      end
   end

   // result formation
   logic [11:0]             blur_sum;
   logic [31:0]             col_wide, col_m1_wide;
   logic [ROW_BITS-1:0]     row_m1;
   logic                    r_first, r_body, c_first;
   logic                    v0, v1, v2;
   gblur3_result_type       res0, res1, res2;
   gblur3_push_type         push;

   always_comb begin
      blur_sum = 12'(win_ff[3]) + {3'b0, win_ff[0], 1'b0} + 12'(top)
               + {3'b0, win_ff[4], 1'b0} + {2'b0, win_ff[1], 2'b0}
               + {3'b0, mid, 1'b0}
               + 12'(win_ff[5]) + {3'b0, win_ff[2], 1'b0} + 12'(s1_px_ff);
      col_wide    = 32'(s1_col_ff);
      col_m1_wide = col_wide - 32'd1;
      row_m1      = s1_row_ff - ROW_BITS'(1);
      r_first     = (s1_row_ff == '0);
      r_body      = (s1_row_ff[ROW_BITS-1:1] != '0);
      c_first     = (s1_col_ff == '0);

      v0 = r_first || (r_body && (s1_col_ff != CW'(1)));
      v1 = r_body && s1_last_col_ff;
      v2 = s1_last_row_ff;

      if (r_first) begin
         res0 = '{pixel: s1_px_ff, row: '0, col: col_wide[OUT_COL_BITS-1:0],
                  border: 1'b1, last: 1'b0};
      end else if (c_first) begin
         res0 = '{pixel: mid, row: row_m1, col: '0, border: 1'b1, last: 1'b0};
      end else begin
         res0 = '{pixel: blur_sum[11:4], row: row_m1,
                  col: col_m1_wide[OUT_COL_BITS-1:0], border: 1'b0, last: 1'b0};
      end
      res0.last = !v1 && !v2;

      res1 = '{pixel: mid, row: row_m1, col: col_wide[OUT_COL_BITS-1:0],
               border: 1'b1, last: !v2};
      res2 = '{pixel: s1_px_ff, row: s1_row_ff, col: col_wide[OUT_COL_BITS-1:0],
               border: 1'b1, last: 1'b1};

      // pack valid results to the front
      push.entry[0] = v0 ? res0 : (v1 ? res1 : res2);
      push.entry[1] = (v0 && v1) ? res1 : res2;
      push.entry[2] = res2;
      push.count    = s1_valid_ff ? (2'(v0) + 2'(v1) + 2'(v2)) : 2'd0;
   end

   gblur3_result_type           head;
   logic [QUEUE_LEVEL_BITS-1:0] level;

   gblur3_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_valid && !rsp_stall),
      .head_valid (rsp_valid),
      .head       (head),
      .level      (level)
   );

   // hold off when the queue could not take this request's results later
   assign req_stall = reset
      || ((5'(level) + 5'(push.count)) > 5'(QUEUE_DEPTH - MAX_RESULTS));

   assign rsp_pixel_out   = head.pixel;
   assign rsp_out_row     = head.row;
   assign rsp_out_col     = head.col;
   assign rsp_is_border   = head.border;
   assign rsp_last_of_run = head.last;

   `GB_ASSERT_NOW(a_queue_room, clock, reset, s1_valid_ff,
      (5'(level) + 5'(push.count)) <= 5'(QUEUE_DEPTH), "result queue overflow")

   `GB_ASSERT_NEXT(a_accept_reaches_stage, clock, reset, accept, s1_valid_ff,
      "accepted request missing from input stage")

   `GB_ASSERT_NOW(a_first_row_single, clock, reset, s1_valid_ff && r_first,
      push.count == 2'd1, "first image row must give one result per request")

   `GB_ASSERT_NOW(a_row_end_border, clock, reset, s1_valid_ff && r_body && s1_last_col_ff,
      push.count >= 2'd2, "row end must add a right border result")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 gaussian blur unit. A software copy of the
// line stores, window and raster counters predicts every result of each
// accepted pixel request. Results are checked in order, field by field.
// The run covers directed images at the size extremes, size changes in the
// middle of an image, and random images under three sender and receiver
// idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gblur3_pkg::*;

   localparam int LINE_WIDTH_MAX = 1024;
   localparam int WIDE_RUN       = 48;
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 200;
   localparam int CYCLE_LIMIT    = 400000;
   // indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [PIXEL_BITS-1:0]     req_pixel_in = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b1;
   logic [PIXEL_BITS-1:0]     rsp_pixel_out;
   logic [ROW_BITS-1:0]       rsp_out_row;
   logic [OUT_COL_BITS-1:0]   rsp_out_col;
   logic                      rsp_is_border;
   logic                      rsp_last_of_run;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // blur predictor state
   logic [PIXEL_BITS-1:0]      older_line [LINE_WIDTH_MAX];
   logic [PIXEL_BITS-1:0]      newer_line [LINE_WIDTH_MAX];
   logic [PIXEL_BITS-1:0]      col_m1 [3];
   logic [PIXEL_BITS-1:0]      col_m2 [3];
   int unsigned                blur_row;
   int unsigned                blur_col;
   logic [CFG_WIDTH_BITS-1:0]  cfg_width;
   logic [CFG_HEIGHT_BITS-1:0] cfg_height;

   gblur3_result_type expected_px [$];

   int          error_count   = 0;
   int unsigned pixels_sent   = 0;
   int unsigned cycle_count   = 0;
   int          req_idle_pct  = 0;
   int          rsp_idle_pct  = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;

   gaussian_blur_3x3_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_is_border   (rsp_is_border),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void reset_predictor();
      foreach (older_line[i]) older_line[i] = '0;
      foreach (newer_line[i]) newer_line[i] = '0;
      foreach (col_m1[i]) begin
         col_m1[i] = '0;
         col_m2[i] = '0;
      end
      blur_row   = 0;
      blur_col   = 0;
      cfg_width  = CFG_WIDTH_BITS'(640);
      cfg_height = CFG_HEIGHT_BITS'(480);
   endfunction

   function automatic int unsigned eff_width();
      int unsigned w;
      w = cfg_width;
      if (w < 3) w = 3;
      if (w > LINE_WIDTH_MAX) w = LINE_WIDTH_MAX;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = cfg_height;
      if (h < 3) h = 3;
      return h;
   endfunction

   // true when the next pixel lands on row 0, column 0
   function automatic bit at_image_start();
      int unsigned r, c;
      r = blur_row;
      c = blur_col;
      if (c >= eff_width()) begin
         c = 0;
         r++;
      end
      if (r >= eff_height()) r = 0;
      return (r == 0 && c == 0);
   endfunction

   function automatic gblur3_result_type make_result(input logic [PIXEL_BITS-1:0] pix,
                                                     input int unsigned row,
                                                     input int unsigned col,
                                                     input logic border);
      gblur3_result_type res;
      res.pixel  = pix;
      res.row    = ROW_BITS'(row);
      res.col    = OUT_COL_BITS'(col);
      res.border = border;
      res.last   = 1'b0;
      return res;
   endfunction

   task automatic predict_blur(input logic [PIXEL_BITS-1:0] px);
      int unsigned w, h, r, c, sum;
      logic [PIXEL_BITS-1:0] top, mid;
      gblur3_result_type run [$];
      w = eff_width();
      h = eff_height();
      // counters left outside a shrunk image wrap before the pixel is placed
      if (blur_col >= w) begin
         blur_col = 0;
         blur_row++;
      end
      if (blur_row >= h) blur_row = 0;
      r   = blur_row;
      c   = blur_col;
      top = older_line[c];
      mid = newer_line[c];

      if (r == 0) begin
         run.push_back(make_result(px, r, c, 1'b1));
      end else if (r >= 2) begin
         if (c == 0) run.push_back(make_result(mid, r - 1, 0, 1'b1));
         if (c >= 2) begin
            sum = col_m2[0] + 2 * col_m1[0] + top
                + 2 * col_m2[1] + 4 * col_m1[1] + 2 * mid
                + col_m2[2] + 2 * col_m1[2] + px;
            run.push_back(make_result(PIXEL_BITS'(sum >> 4), r - 1, c - 1, 1'b0));
         end
         if (c == w - 1) run.push_back(make_result(mid, r - 1, c, 1'b1));
      end
      if (r == h - 1) run.push_back(make_result(px, r, c, 1'b1));
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_px.push_back(run[i]);

      col_m2 = col_m1;
      col_m1[0] = top;
      col_m1[1] = mid;
      col_m1[2] = px;
      older_line[c] = mid;
      newer_line[c] = px;

      blur_col = c + 1;
      if (blur_col >= w) begin
         blur_col = 0;
         blur_row = r + 1;
         if (blur_row >= h) blur_row = 0;
      end
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] px);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid    <= 1'b0;
         req_pixel_in <= PIXEL_BITS'($urandom);
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_blur(px);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH: begin
            cfg_width = data[CFG_WIDTH_BITS-1:0];
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_height = data[CFG_HEIGHT_BITS-1:0];
         end
         default: begin
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idle(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   // random upper bits ride along, only the low 11 reach the register
   function automatic logic [CSR_DATA_BITS-1:0] width_word(input int unsigned cols);
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'($urandom);
      word[CFG_WIDTH_BITS-1:0] = CFG_WIDTH_BITS'(cols);
      return word;
   endfunction

   function automatic int unsigned pick_cols();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return $urandom_range(0, 2);
      if (pick < 75) return $urandom_range(3, 8);
      return $urandom_range(9, 40);
   endfunction

   function automatic int unsigned pick_rows();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return $urandom_range(0, 2);
      if (pick < 90) return $urandom_range(3, 8);
      if (pick < 95) return 65535;
      return $urandom_range(1000, 65534);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] rand_pixel();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 12) return '0;
      if (pick < 24) return '1;
      return PIXEL_BITS'($urandom);
   endfunction

   // pad the current image out with random pixels; tall images are cut short
   task automatic finish_image();
      if (eff_height() > 16) begin
         wait_idle();
         csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'($urandom_range(3, 6)));
      end
      while (!at_image_start()) send_pixel(rand_pixel());
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_size();
      int i;
      for (i = 0; i < 8; i++) send_pixel(i[0] ? '1 : PIXEL_BITS'(i * 17));
      wait_idle();
   endtask

   task automatic test_spare_registers();
      csr_write(CSR_SPARE_2, '1);
      csr_write(CSR_SPARE_3, '0);
   endtask

   task automatic test_small_images();
      int r, c;
      // column 8 lies past the new width, so the next pixel starts row 1
      csr_write(CSR_IMAGE_WIDTH, width_word(0));
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(2));
      finish_image();
      for (r = 0; r < 9; r++) send_pixel('1);
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) send_pixel(((r + c) % 2) ? '1 : '0);
      end
      wait_idle();
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(5));
      for (r = 0; r < 10; r++) send_pixel(rand_pixel());
      // row 3 is beyond the new height, wraps to row 0
      wait_idle();
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(3));
      finish_image();
      wait_idle();
   endtask

   task automatic test_widest_row();
      int i;
      finish_image();
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 16'hFFFF);
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(3));
      // a long stretch of the saturated first row, then the width drops so
      // the column lies past it and wraps to row 1
      for (i = 0; i < WIDE_RUN; i++) send_pixel(rand_pixel());
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, width_word(4));
      finish_image();
      wait_idle();
   endtask

   task automatic run_random_phase(input int unsigned n_items);
      int unsigned stop_at, burst, i;
      bit hold_done, pause_done;
      stop_at    = pixels_sent + n_items;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      while (pixels_sent < stop_at) begin
         finish_image();
         wait_idle();
         csr_write(CSR_IMAGE_WIDTH, width_word(pick_cols()));
         csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(pick_rows()));
         burst = eff_width() * $urandom_range(1, 6) + $urandom_range(0, eff_width() - 1);
         if (!hold_done) burst += 40;
         for (i = 0; i < burst; i++) begin
            // long receiver hold while requests keep coming
            if (!hold_done && i == 4) begin
               hold_requests <= hold_requests + 1;
               hold_done = 1'b1;
            end
            if (!pause_done && i == burst / 2) begin
               wait_idle();
               pause_done = 1'b1;
            end
            send_pixel(rand_pixel());
         end
         // size change in the middle of an image, never a wider row
         if ($urandom_range(2) == 0) begin
            wait_idle();
            if ($urandom_range(1))
               csr_write(CSR_IMAGE_WIDTH, width_word($urandom_range(0, eff_width())));
            else
               csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'($urandom_range(0, 8)));
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES - 1;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic void note_mismatch(input string field, input int unsigned want,
                                         input int unsigned got);
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      error_count++;
   endfunction

   always @(posedge clock) begin
      gblur3_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_px.size() == 0) begin
            $display("%0t: unexpected result expected none actual px %0d row %0d col %0d",
                     $time, rsp_pixel_out, rsp_out_row, rsp_out_col);
            error_count++;
         end else begin
            want = expected_px.pop_front();
            if (rsp_pixel_out !== want.pixel)
               note_mismatch("pixel_out", want.pixel, rsp_pixel_out);
            if (rsp_out_row !== want.row)
               note_mismatch("out_row", want.row, rsp_out_row);
            if (rsp_out_col !== want.col)
               note_mismatch("out_col", want.col, rsp_out_col);
            if (rsp_is_border !== want.border)
               note_mismatch("is_border", want.border, rsp_is_border);
            if (rsp_last_of_run !== want.last)
               note_mismatch("last_of_run", want.last, rsp_last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_px.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset_predictor();
      set_idle(23, 67);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_spare_registers();
      test_small_images();
      test_widest_row();

      set_idle(23, 67);
      run_random_phase(100);
      set_idle(67, 23);
      run_random_phase(100);
      set_idle(0, 0);
      run_random_phase(100);

      wait_idle();
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/gblur3_pkg.sv
src/gblur3_ram.sv
src/gblur3_result_queue.sv
src/gaussian_blur_3x3_unit.sv
sim/tb_top.sv
